// ----- sv/key_press_event_detector_macros.svh -----
// assertion macros for the key press event detector
// included by every rtl file that carries concurrent assertions
`ifndef KEY_PRESS_EVENT_DETECTOR_MACROS_SVH
`define KEY_PRESS_EVENT_DETECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked property, switched off while reset is asserted
`define KPED_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also checked during reset
`define KPED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KPED_ASSERT(lbl, clk, rst_n, prop, msg)
`define KPED_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- sv/kped_pkg.sv -----
// shared types, constants and helpers for the key press event detector
// no dependencies
package kped_pkg;

  localparam int NUM_KEYS  = 3;
  localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CNT_W     = 16;
  localparam int CODE_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CNT_W-1:0] LONG_RST     = 16'd200;
  localparam logic [CNT_W-1:0] REPEAT_RST   = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_REPEAT   = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    EV_PRESS         = 3'd0,
    EV_SHORT_RELEASE = 3'd1,
    EV_LONG_PRESS    = 3'd2,
    EV_REPEAT        = 3'd3,
    EV_LONG_RELEASE  = 3'd4
  } evt_kind_e;

  typedef struct packed {
    logic [CNT_W-1:0] debounce;
    logic [CNT_W-1:0] long_press;
    logic [CNT_W-1:0] repeat_period;
  } cfg_t;

  typedef struct packed {
    logic      fire;
    evt_kind_e kind;
  } lane_evt_t;

  // key * 5 + kind + 1, kept to the code width
  function automatic logic [CODE_W-1:0] event_code(input logic [KEY_IDX_W-1:0] key,
                                                   input evt_kind_e kind);
    logic [7:0] t;
    t = 8'(key) * 8'd5 + 8'(kind) + 8'd1;
    return t[CODE_W-1:0];
  endfunction

endpackage

// ----- sv/key_press_event_detector.sv -----
// top level of the key press event detector: config registers, key lanes, merge
// depends on kped_pkg, kped_lane and kped_merge
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------
//   in      | in        | in_valid_i / in_stall_o   | key_levels_i
//   out     | out       | out_valid_o / out_stall_i | key_index_o, event_kind_o,
//           |           |                           | event_code_o, last_event_o
//   cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// a tick transaction is taken in one cycle; every lane updates in that same cycle
// a tick that raises events holds in_stall_o while the merge stage drains them,
// one per cycle while the output is not stalled
// the single output register lets the next tick in while the last event still waits
// reset puts all keys idle, counters and registers at their reset values
// cfg writes are always taken and act at the next counter reload
module key_press_event_detector
  import kped_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // scan tick input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [NUM_KEYS-1:0]  key_levels_i,
  // event output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [KEY_IDX_W-1:0] key_index_o,
  output logic [2:0]           event_kind_o,
  output logic [CODE_W-1:0]    event_code_o,
  output logic                 last_event_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  logic      tick;
  logic      busy;
  lane_evt_t evt [NUM_KEYS];

  // register file, an unused index is dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DEBOUNCE: cfg_d.debounce      = cfg_data_i;
        REG_LONG:     cfg_d.long_press    = cfg_data_i;
        REG_REPEAT:   cfg_d.repeat_period = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce      <= DEBOUNCE_RST;
      cfg_q.long_press    <= LONG_RST;
      cfg_q.repeat_period <= REPEAT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // a tick is held off only while the previous tick's events are still pending
  assign in_stall_o = busy;
  assign tick       = in_valid_i && !in_stall_o;

  // one lane per key
  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
    kped_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cfg_i     (cfg_q),
      .tick_i    (tick),
      .pressed_i (key_levels_i[g]),
      .evt_o     (evt[g])
    );
  end

  // collect lane events and hand them out in key order
  kped_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .evt_i        (evt),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_index_o  (key_index_o),
    .event_kind_o (event_kind_o),
    .event_code_o (event_code_o),
    .last_event_o (last_event_o)
  );

endmodule

// ----- sv/kped_lane.sv -----
// one key lane: four-phase machine with its debounce, long and repeat counters
// depends on kped_pkg
module kped_lane
  import kped_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      tick_i,
  input  logic      pressed_i,
  output lane_evt_t evt_o
);

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HELD     = 2'd2,
    PH_REPEAT   = 2'd3
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] deb_q, deb_d;
  logic [CNT_W-1:0] lng_q, lng_d;
  logic [CNT_W-1:0] rpt_q, rpt_d;
  logic [CNT_W-1:0] dec;

  always_comb begin
    phase_d    = phase_q;
    deb_d      = deb_q;
    lng_d      = lng_q;
    rpt_d      = rpt_q;
    evt_o.fire = 1'b0;
    evt_o.kind = EV_PRESS;
    dec        = '0;
    if (tick_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (pressed_i) phase_d = PH_DEBOUNCE;
        end
        PH_DEBOUNCE: begin
          dec = deb_q - 1'b1;
          if (!pressed_i) begin
            deb_d   = cfg_i.debounce;
            phase_d = PH_IDLE;
          end else if (dec == '0) begin
            deb_d      = cfg_i.debounce;
            phase_d    = PH_HELD;
            evt_o.fire = 1'b1;
            evt_o.kind = EV_PRESS;
          end else begin
            deb_d = dec;
          end
        end
        PH_HELD: begin
          dec = lng_q - 1'b1;
          if (!pressed_i) begin
            lng_d      = cfg_i.long_press;
            phase_d    = PH_IDLE;
            evt_o.fire = 1'b1;
            evt_o.kind = EV_SHORT_RELEASE;
          end else if (dec == '0) begin
            lng_d      = cfg_i.long_press;
            phase_d    = PH_REPEAT;
            evt_o.fire = 1'b1;
            evt_o.kind = EV_LONG_PRESS;
          end else begin
            lng_d = dec;
          end
        end
        PH_REPEAT: begin
          dec = rpt_q - 1'b1;
          if (!pressed_i) begin
            rpt_d      = cfg_i.repeat_period;
            phase_d    = PH_IDLE;
            evt_o.fire = 1'b1;
            evt_o.kind = EV_LONG_RELEASE;
          end else if (dec == '0) begin
            rpt_d      = cfg_i.repeat_period;
            evt_o.fire = 1'b1;
            evt_o.kind = EV_REPEAT;
          end else begin
            rpt_d = dec;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      deb_q   <= DEBOUNCE_RST;
      lng_q   <= LONG_RST;
      rpt_q   <= REPEAT_RST;
    end else begin
      phase_q <= phase_d;
      deb_q   <= deb_d;
      lng_q   <= lng_d;
      rpt_q   <= rpt_d;
    end
  end

endmodule

// ----- sv/kped_merge.sv -----
// merge stage: latches the lane events of one tick and drains them in key order
// depends on kped_pkg and the assertion macro header
`include "key_press_event_detector_macros.svh"

module kped_merge
  import kped_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tick_i,
  input  lane_evt_t             evt_i [NUM_KEYS],
  output logic                  busy_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KEY_IDX_W-1:0]  key_index_o,
  output logic [2:0]            event_kind_o,
  output logic [CODE_W-1:0]     event_code_o,
  output logic                  last_event_o
);

  logic [NUM_KEYS-1:0]  pend_q, pend_d;
  evt_kind_e            kind_q [NUM_KEYS];
  logic [NUM_KEYS-1:0]  pick;
  logic [KEY_IDX_W-1:0] sel;
  logic                 load;
  logic                 out_valid_q, out_valid_d;
  logic [KEY_IDX_W-1:0] key_q;
  evt_kind_e            okind_q;
  logic [CODE_W-1:0]    code_q;
  logic                 last_q;

  // lowest pending key wins
  always_comb begin
    pick = '0;
    sel  = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (pend_q[k]) begin
        pick = '0;
        pick[k] = 1'b1;
        sel  = KEY_IDX_W'(k);
      end
    end
  end

  assign load = (|pend_q) && !(out_valid_q && out_stall_i);

  always_comb begin
    pend_d      = pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (tick_i) begin
      for (int k = 0; k < NUM_KEYS; k++) pend_d[k] = evt_i[k].fire;
    end
    if (load) begin
      pend_d      = pend_q & ~pick;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i) begin
      for (int k = 0; k < NUM_KEYS; k++) kind_q[k] <= evt_i[k].kind;
    end
    if (load) begin
      key_q   <= sel;
      okind_q <= kind_q[sel];
      code_q  <= event_code(sel, kind_q[sel]);
      last_q  <= (pend_q & ~pick) == '0;
    end
  end

  assign busy_o       = |pend_q;
  assign out_valid_o  = out_valid_q;
  assign key_index_o  = key_q;
  assign event_kind_o = okind_q;
  assign event_code_o = code_q;
  assign last_event_o = last_q;

  `KPED_ASSERT(a_tick_only_when_drained, clk_i, rst_ni, tick_i |-> pend_q == '0, "tick taken with events pending")
  `KPED_ASSERT(a_drain_progress, clk_i, rst_ni, ((pend_q != '0) && !(out_valid_q && out_stall_i)) |=> out_valid_q, "pending event not moved to output")
  `KPED_ASSERT(a_more_after_non_last, clk_i, rst_ni, (out_valid_q && !last_q) |-> pend_q != '0, "non-last event with nothing left")
  `KPED_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> (pend_q == '0 && !out_valid_q), "merge not idle in reset")

endmodule

// ----- tb/kped_event_checker.sv -----
// event checker for the key press event detector: mirrors every key lane and compares events
// depends on kped_pkg; instantiated beside the block by tb_key_press_event_detector
module kped_event_checker
  import kped_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [NUM_KEYS-1:0]  key_levels_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [KEY_IDX_W-1:0] key_index_i,
  input  logic [2:0]           event_kind_i,
  input  logic [CODE_W-1:0]    event_code_i,
  input  logic                 last_event_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  input  logic                 test_done_i,
  output int                   pending_o,
  output int                   fail_count_o
);

  localparam logic [CNT_W-1:0] DEBOUNCE_AT_RESET = 16'd20;
  localparam logic [CNT_W-1:0] LONG_AT_RESET     = 16'd200;
  localparam logic [CNT_W-1:0] REPEAT_AT_RESET   = 16'd50;

  typedef enum logic [1:0] {
    KEY_IDLE      = 2'd0,
    KEY_DEBOUNCE  = 2'd1,
    KEY_HELD      = 2'd2,
    KEY_REPEATING = 2'd3
  } key_phase_e;

  typedef struct packed {
    logic [KEY_IDX_W-1:0] key;
    evt_kind_e            kind;
    logic [CODE_W-1:0]    code;
    logic                 last;
  } key_event_t;

  cfg_t             timing;
  key_phase_e       key_phase    [NUM_KEYS];
  logic [CNT_W-1:0] debounce_cnt [NUM_KEYS];
  logic [CNT_W-1:0] long_cnt     [NUM_KEYS];
  logic [CNT_W-1:0] repeat_cnt   [NUM_KEYS];
  key_event_t       expected_events [$];
  int               fail_count = 0;
  bit               done_seen  = 1'b0;

  // one scan tick through every key lane, events queued in key order
  task automatic predict_tick(input logic [NUM_KEYS-1:0] levels);
    key_event_t tick_events [$];
    key_event_t ev;
    bit         fire;
    evt_kind_e  kind;
    for (int k = 0; k < NUM_KEYS; k++) begin
      fire = 1'b0;
      kind = EV_PRESS;
      case (key_phase[k])
        KEY_IDLE: begin
          if (levels[k]) key_phase[k] = KEY_DEBOUNCE;
        end
        KEY_DEBOUNCE: begin
          if (levels[k]) begin
            debounce_cnt[k] = debounce_cnt[k] - 16'd1;
            if (debounce_cnt[k] == '0) begin
              debounce_cnt[k] = timing.debounce;
              key_phase[k]    = KEY_HELD;
              fire            = 1'b1;
              kind            = EV_PRESS;
            end
          end else begin
            // bounce: back to idle silently
            debounce_cnt[k] = timing.debounce;
            key_phase[k]    = KEY_IDLE;
          end
        end
        KEY_HELD: begin
          if (levels[k]) begin
            long_cnt[k] = long_cnt[k] - 16'd1;
            if (long_cnt[k] == '0) begin
              long_cnt[k]  = timing.long_press;
              key_phase[k] = KEY_REPEATING;
              fire         = 1'b1;
              kind         = EV_LONG_PRESS;
            end
          end else begin
            long_cnt[k]  = timing.long_press;
            key_phase[k] = KEY_IDLE;
            fire         = 1'b1;
            kind         = EV_SHORT_RELEASE;
          end
        end
        default: begin
          // repeat counter is not reloaded on entry, it carries its old value
          if (levels[k]) begin
            repeat_cnt[k] = repeat_cnt[k] - 16'd1;
            if (repeat_cnt[k] == '0) begin
              repeat_cnt[k] = timing.repeat_period;
              fire          = 1'b1;
              kind          = EV_REPEAT;
            end
          end else begin
            repeat_cnt[k] = timing.repeat_period;
            key_phase[k]  = KEY_IDLE;
            fire          = 1'b1;
            kind          = EV_LONG_RELEASE;
          end
        end
      endcase
      if (fire) begin
        ev.key  = KEY_IDX_W'(k);
        ev.kind = kind;
        ev.code = CODE_W'(k * 5 + int'(kind) + 1);
        ev.last = 1'b0;
        tick_events.push_back(ev);
      end
    end
    if (tick_events.size() > 0) tick_events[tick_events.size() - 1].last = 1'b1;
    foreach (tick_events[i]) expected_events.push_back(tick_events[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    key_event_t want;
    if (!rst_ni) begin
      timing.debounce      = DEBOUNCE_AT_RESET;
      timing.long_press    = LONG_AT_RESET;
      timing.repeat_period = REPEAT_AT_RESET;
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_phase[k]    = KEY_IDLE;
        debounce_cnt[k] = DEBOUNCE_AT_RESET;
        long_cnt[k]     = LONG_AT_RESET;
        repeat_cnt[k]   = REPEAT_AT_RESET;
      end
      expected_events.delete();
    end else begin
      // new timing only takes effect at the next reload
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DEBOUNCE: timing.debounce      = cfg_data_i;
          REG_LONG:     timing.long_press    = cfg_data_i;
          REG_REPEAT:   timing.repeat_period = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_tick(key_levels_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event, got key %0d kind %0d code %0d last %0d",
                   $time, key_index_i, event_kind_i, event_code_i, last_event_i);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (key_index_i !== want.key) begin
            $display("%0t: key_index mismatch, expected %0d, got %0d",
                     $time, want.key, key_index_i);
            fail_count++;
          end
          if (event_kind_i !== 3'(want.kind)) begin
            $display("%0t: event_kind mismatch, expected %0d, got %0d",
                     $time, want.kind, event_kind_i);
            fail_count++;
          end
          if (event_code_i !== want.code) begin
            $display("%0t: event_code mismatch, expected %0d, got %0d",
                     $time, want.code, event_code_i);
            fail_count++;
          end
          if (last_event_i !== want.last) begin
            $display("%0t: last_event mismatch, expected %0d, got %0d",
                     $time, want.last, last_event_i);
            fail_count++;
          end
        end
      end
      if (test_done_i && !done_seen) begin
        done_seen = 1'b1;
        if (expected_events.size() > 0) begin
          $display("%0t: %0d events never seen, oldest expected key %0d kind %0d",
                   $time, expected_events.size(), expected_events[0].key,
                   expected_events[0].kind);
          fail_count += expected_events.size();
        end
      end
    end
    pending_o    = expected_events.size();
    fail_count_o = fail_count;
  end

endmodule

// ----- tb/tb_key_press_event_detector.sv -----
// testbench top for the key press event detector: clock, reset, stimulus and verdict
// depends on kped_pkg, key_press_event_detector and kped_event_checker
module tb_key_press_event_detector
  import kped_pkg::*;
();

  // cycles allowed after the last expected event for stray events to show
  localparam int SETTLE_CYCLES = 10;
  // a register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  // cap on each timing span used to shape press lengths
  localparam int RUN_CAP = 12;

  typedef enum logic [1:0] {
    STALL_NONE     = 2'd0,
    STALL_RANDOM   = 2'd1,
    STALL_PERIODIC = 2'd2,
    STALL_HEAVY    = 2'd3
  } stall_mode_e;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [NUM_KEYS-1:0]  key_levels = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [KEY_IDX_W-1:0] key_index;
  logic [2:0]           event_kind;
  logic [CODE_W-1:0]    event_code;
  logic                 last_event;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CNT_W-1:0]     cfg_data   = '0;
  logic                 test_done  = 1'b0;
  int                   pending;
  int                   fail_count;

  // sender burst state
  int                  burst_left = 0;
  // per key press pattern state
  logic [NUM_KEYS-1:0] held = '0;
  int                  run_left [NUM_KEYS];
  // current timing, clipped to keep the press patterns short
  int                  debounce_span = RUN_CAP;
  int                  long_span     = RUN_CAP;
  int                  repeat_span   = RUN_CAP;
  // receiver stall state
  stall_mode_e         stall_mode      = STALL_NONE;
  int                  stall_mode_left = 0;
  int                  stall_run       = 0;
  int                  stall_cycle     = 0;

  key_press_event_detector dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .key_levels_i (key_levels),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .key_index_o  (key_index),
    .event_kind_o (event_kind),
    .event_code_o (event_code),
    .last_event_o (last_event),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  kped_event_checker u_event_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .key_levels_i (key_levels),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .key_index_i  (key_index),
    .event_kind_i (event_kind),
    .event_code_i (event_code),
    .last_event_i (last_event),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .test_done_i  (test_done),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("key_press_event_detector verification failed");
    $finish;
  end

  // receiver back-pressure: one of four stall modes, redrawn at random
  // stall runs are capped so a waiting event is never held for long
  always @(negedge clk) begin : receiver_stall
    logic stall_next;
    if (stall_mode_left == 0) begin
      stall_mode      = stall_mode_e'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(20, 120);
    end else begin
      stall_mode_left--;
    end
    stall_cycle++;
    case (stall_mode)
      STALL_RANDOM:   stall_next = ($urandom_range(0, 9) < 3);
      STALL_PERIODIC: stall_next = ((stall_cycle % 4) != 0);
      STALL_HEAVY:    stall_next = ($urandom_range(0, 9) < 7);
      default:        stall_next = 1'b0;
    endcase
    if (stall_run >= 6) stall_next = 1'b0;
    stall_run = stall_next ? stall_run + 1 : 0;
    out_stall <= stall_next;
  end

  // one tick transaction; between bursts the valid may drop for a random gap
  // and the levels carry junk, which the block must ignore
  task automatic send_tick(input logic [NUM_KEYS-1:0] levels);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid   <= 1'b0;
        key_levels <= NUM_KEYS'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    key_levels <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // one register write transaction
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop ticks, let every expected event drain, then leave room for stragglers
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // press length chosen to land in debounce, in held or deep in repeating
  function automatic int press_length();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, debounce_span);
      1:       return $urandom_range(debounce_span + 1, debounce_span + long_span);
      default: return $urandom_range(debounce_span + long_span + 1,
                                     debounce_span + long_span + 3 * repeat_span + 1);
    endcase
  endfunction

  // every key presses and releases on its own schedule, with rare glitches on top
  task automatic press_pattern(input int ticks);
    logic [NUM_KEYS-1:0] levels;
    for (int t = 0; t < ticks; t++) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (run_left[k] == 0) begin
          held[k]     = ~held[k];
          run_left[k] = held[k] ? press_length() : $urandom_range(1, 4);
        end
        run_left[k]--;
      end
      levels = held;
      if ($urandom_range(0, 9) == 0) levels ^= NUM_KEYS'(1) << $urandom_range(0, NUM_KEYS - 1);
      send_tick(levels);
    end
  endtask

  // new timing written while idle; counters still mid-count keep their values
  task automatic run_phase(input logic [CNT_W-1:0] deb, input logic [CNT_W-1:0] lng,
                           input logic [CNT_W-1:0] rep, input int ticks);
    wait_quiet();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG, lng);
    write_reg(REG_REPEAT, rep);
    debounce_span = (deb == '0 || deb > RUN_CAP) ? RUN_CAP : int'(deb);
    long_span     = (lng == '0 || lng > RUN_CAP) ? RUN_CAP : int'(lng);
    repeat_span   = (rep == '0 || rep > RUN_CAP) ? RUN_CAP : int'(rep);
    press_pattern(ticks);
  endtask

  initial begin
    foreach (run_left[k]) run_left[k] = $urandom_range(1, 4);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset timing: a bounce on key 1 gives nothing, then all keys held
    // through the full debounce give three presses, released together
    send_tick(3'b010);
    send_tick(3'b000);
    repeat (21) send_tick(3'b111);
    send_tick(3'b000);

    run_phase(16'd1, 16'd1, 16'd1, 50);
    run_phase(16'd2, 16'd4, 16'd3, 50);
    // zero debounce: after a reload the next decrement wraps
    run_phase(16'd0, 16'd3, 16'd2, 50);
    // write to an unmapped index must change nothing
    wait_quiet();
    write_reg(REG_UNMAPPED, 16'hA5C3);
    run_phase(16'd4, 16'd6, 16'd5, 50);
    // largest periods: almost nothing fires, counters carry into the next phase
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 40);
    run_phase(16'd3, 16'd0, 16'd2, 50);
    run_phase(16'd5, 16'd8, 16'd0, 45);
    run_phase(CNT_W'($urandom_range(1, 8)), CNT_W'($urandom_range(1, 8)),
              CNT_W'($urandom_range(1, 8)), 50);
    run_phase(16'd1, 16'd2, 16'd1, 50);

    wait_quiet();
    @(negedge clk);
    test_done <= 1'b1;
    @(negedge clk);
    if (fail_count == 0) begin
      $display("key_press_event_detector verification clean");
    end else begin
      $display("key_press_event_detector verification failed");
    end
    $finish;
  end

endmodule
